/* rtl/gn3_pkg.sv */
// Shared types and constants for the 3D gradient noise evaluator.
// Used by gn3_front, gn3_back and gradient_noise_3d_top; depends on nothing.
package gn3_pkg;

  typedef enum logic [1:0] {
    OP_EVAL = 2'd0,
    OP_PERM = 2'd1,
    OP_GRAD = 2'd2
  } op_e;

  // One queued word, as accepted on the input channel.
  typedef struct packed {
    op_e                op;
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
    logic [7:0]         idx;
    logic [7:0]         pval;
    logic signed [15:0] gx;
    logic signed [15:0] gy;
    logic signed [15:0] gz;
  } item_t;

  // Back-end status seen by the top level.
  typedef struct packed {
    logic load_wr;
    logic rd_busy;
  } bk_stat_t;

  localparam logic [17:0] SMOOTH_K = 18'd196608; // 3.0 in Q16
  localparam logic [50:0] WGT_RND  = 51'd2147483648;
  localparam logic signed [35:0] OUT_RND = 36'sd8192;

endpackage

/* rtl/gn3_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// Stand-alone; no package needed.
module gn3_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end
endmodule

/* rtl/gn3_front.sv */
// Front end: input handshake, operation sorting and the word queue.
// Depends on gn3_pkg.
module gn3_front #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          operation_i,
  input  logic signed [31:0]  coord_x_i,
  input  logic signed [31:0]  coord_y_i,
  input  logic signed [31:0]  coord_z_i,
  input  logic [7:0]          table_index_i,
  input  logic [7:0]          perm_value_i,
  input  logic signed [15:0]  grad_x_in_i,
  input  logic signed [15:0]  grad_y_in_i,
  input  logic signed [15:0]  grad_z_in_i,
  output logic                q_valid_o,
  output gn3_pkg::item_t      q_item_o,
  input  logic                q_pop_i
);
  localparam int PW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  gn3_pkg::item_t mem_q [QUEUE_DEPTH];
  gn3_pkg::item_t item;
  logic [PW-1:0]  wr_ptr_q, wr_ptr_d, rd_ptr_q, rd_ptr_d;
  logic [CW-1:0]  cnt_q, cnt_d;
  logic           push, known_op;

  always_comb begin
    case (operation_i)
      gn3_pkg::OP_EVAL, gn3_pkg::OP_PERM, gn3_pkg::OP_GRAD: known_op = 1'b1;
      default: known_op = 1'b0;
    endcase
  end

  assign in_ready_o = (cnt_q != CW'(QUEUE_DEPTH));
  // Drop the unused selector at the door.
  assign push       = in_valid_i && in_ready_o && known_op;
  assign q_valid_o  = (cnt_q != '0);
  assign q_item_o   = mem_q[rd_ptr_q];

  always_comb begin
    item.op   = gn3_pkg::op_e'(operation_i);
    item.x    = coord_x_i;
    item.y    = coord_y_i;
    item.z    = coord_z_i;
    item.idx  = table_index_i;
    item.pval = perm_value_i;
    item.gx   = grad_x_in_i;
    item.gy   = grad_y_in_i;
    item.gz   = grad_z_in_i;
  end

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (q_pop_i) begin
      rd_ptr_d = (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !q_pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push && q_pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= item;
    end
  end
endmodule

/* rtl/gn3_back.sv */
// Back end: table writes, hash lookups, dot products and trilinear blend.
// Depends on gn3_pkg and gn3_ram.
module gn3_back #(
  parameter int TABLE_SIZE = 256
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                q_valid_i,
  input  gn3_pkg::item_t      q_item_i,
  output logic                q_pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [19:0]  noise_value_o,
  output gn3_pkg::bk_stat_t   stat_o
);
  localparam int AW = $clog2(TABLE_SIZE);

  logic        adv, is_eval, ev_iss, ld_iss, perm_we, grad_we;
  logic [13:1] v_q;
  logic [15:0] idx16;
  logic [AW-1:0] waddr;

  logic [2:0][15:0] c1_q, f1_q, f2_q, f3_q, f4_q;
  logic [15:0]      cx2_q;
  logic [2:0][31:0] sq2_q;
  logic [2:0][17:0] k2_q;
  logic [2:0][49:0] wp3_q;
  logic [2:0][16:0] w_q [4:10];

  logic [AW-1:0] zaddr [2];
  logic [AW-1:0] yaddr [4];
  logic [AW-1:0] xaddr [8];
  logic [AW-1:0] gaddr [8];
  logic [7:0]    pz [2];
  logic [7:0]    py [4];
  logic [7:0]    ph [8];
  logic [47:0]   gd [8];

  logic signed [32:0] pr5_q [8][3];
  logic signed [34:0] d6_q  [8];
  logic signed [35:0] a7_q  [4];
  logic signed [53:0] m7_q  [4];
  logic signed [35:0] l8_q  [4];
  logic signed [35:0] a9_q  [2];
  logic signed [53:0] m9_q  [2];
  logic signed [35:0] l10_q [2];
  logic signed [35:0] a11_q, l12_q, rsum;
  logic signed [53:0] m11_q;
  logic signed [19:0] out_q;

  assign adv     = !v_q[13] || out_ready_i;
  assign is_eval = (q_item_i.op == gn3_pkg::OP_EVAL);
  assign ev_iss  = q_valid_i && is_eval && adv;
  // Hold a table write until no lookup is in flight.
  assign ld_iss  = q_valid_i && !is_eval && !(|v_q[3:1]);
  assign q_pop_o = ev_iss || ld_iss;
  assign perm_we = ld_iss && (q_item_i.op == gn3_pkg::OP_PERM);
  assign grad_we = ld_iss && (q_item_i.op == gn3_pkg::OP_GRAD);
  assign idx16   = {8'h00, q_item_i.idx};
  assign waddr   = idx16[AW-1:0];

  assign stat_o.load_wr = ld_iss;
  assign stat_o.rd_busy = |v_q[3:1];
  assign out_valid_o    = v_q[13];
  assign noise_value_o  = out_q;

  genvar gi;
  generate
    for (gi = 0; gi < 2; gi++) begin : g_z
      logic [15:0] s;
      assign s = q_item_i.z[31:16] + 16'(gi);
      assign zaddr[gi] = s[AW-1:0];
      gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .clk_i, .we_i(perm_we), .waddr_i(waddr), .wdata_i(q_item_i.pval),
        .re_i(adv), .raddr_i(zaddr[gi]), .rdata_o(pz[gi]));
    end
    for (gi = 0; gi < 4; gi++) begin : g_y
      logic [15:0] s;
      assign s = c1_q[1] + 16'(gi % 2) + {8'h00, pz[gi / 2]};
      assign yaddr[gi] = s[AW-1:0];
      gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .clk_i, .we_i(perm_we), .waddr_i(waddr), .wdata_i(q_item_i.pval),
        .re_i(adv), .raddr_i(yaddr[gi]), .rdata_o(py[gi]));
    end
    for (gi = 0; gi < 8; gi++) begin : g_x
      logic [15:0] s, h16;
      assign s = cx2_q + 16'(gi % 2) + {8'h00, py[gi / 2]};
      assign xaddr[gi] = s[AW-1:0];
      gn3_ram #(.WIDTH(8), .DEPTH(TABLE_SIZE)) u_ram (
        .clk_i, .we_i(perm_we), .waddr_i(waddr), .wdata_i(q_item_i.pval),
        .re_i(adv), .raddr_i(xaddr[gi]), .rdata_o(ph[gi]));
      assign h16 = {8'h00, ph[gi]};
      assign gaddr[gi] = h16[AW-1:0];
      gn3_ram #(.WIDTH(48), .DEPTH(TABLE_SIZE)) u_gram (
        .clk_i, .we_i(grad_we), .waddr_i(waddr),
        .wdata_i({q_item_i.gx, q_item_i.gy, q_item_i.gz}),
        .re_i(adv), .raddr_i(gaddr[gi]), .rdata_o(gd[gi]));
    end
  endgenerate

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[12:1], ev_iss};
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      c1_q  <= {q_item_i.z[31:16], q_item_i.y[31:16], q_item_i.x[31:16]};
      f1_q  <= {q_item_i.z[15:0], q_item_i.y[15:0], q_item_i.x[15:0]};
      cx2_q <= c1_q[0];
      f2_q  <= f1_q;
      f3_q  <= f2_q;
      f4_q  <= f3_q;
      for (int a = 0; a < 3; a++) begin
        sq2_q[a] <= f1_q[a] * f1_q[a];
        k2_q[a]  <= gn3_pkg::SMOOTH_K - {1'b0, f1_q[a], 1'b0};
        wp3_q[a] <= sq2_q[a] * k2_q[a];
        w_q[4][a] <= 17'(({1'b0, wp3_q[a]} + gn3_pkg::WGT_RND) >> 32);
      end
      for (int k = 5; k <= 10; k++) begin
        w_q[k] <= w_q[k-1];
      end
      for (int c = 0; c < 8; c++) begin
        pr5_q[c][0] <= $signed(gd[c][47:32]) * $signed({c[0], f4_q[0]});
        pr5_q[c][1] <= $signed(gd[c][31:16]) * $signed({c[1], f4_q[1]});
        pr5_q[c][2] <= $signed(gd[c][15:0])  * $signed({c[2], f4_q[2]});
        d6_q[c] <= 35'(pr5_q[c][0]) + 35'(pr5_q[c][1]) + 35'(pr5_q[c][2]);
      end
      for (int i = 0; i < 4; i++) begin
        a7_q[i] <= 36'(d6_q[2*i]);
        m7_q[i] <= $signed({1'b0, w_q[6][0]}) * (36'(d6_q[2*i+1]) - 36'(d6_q[2*i]));
        l8_q[i] <= a7_q[i] + $signed(m7_q[i][51:16]);
      end
      for (int i = 0; i < 2; i++) begin
        a9_q[i]  <= l8_q[2*i];
        m9_q[i]  <= $signed({1'b0, w_q[8][1]}) * (l8_q[2*i+1] - l8_q[2*i]);
        l10_q[i] <= a9_q[i] + $signed(m9_q[i][51:16]);
      end
      a11_q <= l10_q[0];
      m11_q <= $signed({1'b0, w_q[10][2]}) * (l10_q[1] - l10_q[0]);
      l12_q <= a11_q + $signed(m11_q[51:16]);
      out_q <= rsum[33:14];
    end
  end

  assign rsum = l12_q + gn3_pkg::OUT_RND;
endmodule

/* rtl/gradient_noise_3d_top.sv */
// Top level of the 3D gradient noise evaluator: front end, queue, back end.
// Depends on gn3_pkg, gn3_front, gn3_back (and gn3_ram through gn3_back).
//
//  channel | handshake               | payload
//  --------+-------------------------+-------------------------------------------
//  in      | in_valid_i / in_ready_o | operation, coord_x/y/z, table_index,
//          |                         | perm_value, grad_x/y/z_in
//  out     | out_valid_o/out_ready_i | noise_value (Q3.16)
//
// One evaluate word is taken every cycle while the output is not stalled and
// no table load waits; an accepted word is queued, then leaves the queue into
// the first of 13 pipeline stages (three permutation levels, one gradient read,
// products, dot sums, three blend levels of two stages each, output rounding).
// A table load waits in the queue until no lookup is in flight in the first
// three stages. Reset clears the queue and the pipeline valid bits; tables
// are not cleared. A stall on the output freezes the back-end pipeline, though
// a table load can still be written during it; the queue keeps accepting words
// until it is full.
module gradient_noise_3d_top #(
  parameter int TABLE_SIZE  = 256,
  parameter int QUEUE_DEPTH = 4
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         perm_value_i,
  input  logic signed [15:0] grad_x_in_i,
  input  logic signed [15:0] grad_y_in_i,
  input  logic signed [15:0] grad_z_in_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [19:0] noise_value_o
);
  logic              q_valid, q_pop;
  gn3_pkg::item_t    q_item;
  gn3_pkg::bk_stat_t stat;

  // Sort and queue incoming words.
  gn3_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .table_index_i, .perm_value_i,
    .grad_x_in_i, .grad_y_in_i, .grad_z_in_i,
    .q_valid_o(q_valid), .q_item_o(q_item), .q_pop_i(q_pop)
  );

  // Write tables and evaluate noise.
  gn3_back #(.TABLE_SIZE(TABLE_SIZE)) u_back (
    .clk_i, .rst_ni, .q_valid_i(q_valid), .q_item_i(q_item), .q_pop_o(q_pop),
    .out_valid_o, .out_ready_i, .noise_value_o, .stat_o(stat)
  );

  a_pop_needs_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid) else $error("queue popped while empty");

  a_load_no_lookup: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.load_wr |-> !stat.rd_busy) else $error("table write during lookup");

  a_load_then_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.load_wr |=> !stat.rd_busy) else $error("lookup overlaps table write");

  a_full_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> q_valid) else $error("queue full but empty");
endmodule

/* tb/noise_checker.sv */
`timescale 1ns / 1ps
// Checker for gradient_noise_3d_top: mirrors the permutation and gradient tables,
// predicts each noise word and compares it on the output channel. Depends on gn3_pkg.
module noise_checker (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [1:0]         operation_i,
  input  logic signed [31:0] coord_x_i,
  input  logic signed [31:0] coord_y_i,
  input  logic signed [31:0] coord_z_i,
  input  logic [7:0]         table_index_i,
  input  logic [7:0]         perm_value_i,
  input  logic signed [15:0] grad_x_in_i,
  input  logic signed [15:0] grad_y_in_i,
  input  logic signed [15:0] grad_z_in_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [19:0] noise_value_i,
  output int                 fail_count_o,
  output int                 pending_o
);
  logic [7:0]         perm_mirror [256];
  logic signed [15:0] grad_mirror [256][3];
  logic signed [19:0] noise_expected [$];
  int                 fails = 0;

  function automatic longint smooth_of(longint f);
    longint sq;
    longint k;
    sq = f * f;
    k = 196608 - 2 * f;
    return (sq * k + 64'sd2147483648) >>> 32;
  endfunction

  function automatic longint dot_at(logic [15:0] cx, logic [15:0] cy, logic [15:0] cz,
                                    longint ox, longint oy, longint oz);
    logic [7:0] h;
    h = perm_mirror[8'(cx + perm_mirror[8'(cy + perm_mirror[cz[7:0]])])];
    return longint'(grad_mirror[h][0]) * ox + longint'(grad_mirror[h][1]) * oy
         + longint'(grad_mirror[h][2]) * oz;
  endfunction

  function automatic longint lerp_q30(longint w, longint a, longint b);
    return a + ((w * (b - a)) >>> 16);
  endfunction

  function automatic logic signed [19:0] noise_at(logic [31:0] px, logic [31:0] py,
                                                  logic [31:0] pz);
    logic [15:0] cx, cy, cz;
    longint x0, y0, z0, x1, y1, z1, wx, wy, wz, a, b, lo, hi, r;
    cx = px[31:16]; cy = py[31:16]; cz = pz[31:16];
    x0 = px[15:0]; y0 = py[15:0]; z0 = pz[15:0];
    x1 = x0 - 65536; y1 = y0 - 65536; z1 = z0 - 65536;
    wx = smooth_of(x0); wy = smooth_of(y0); wz = smooth_of(z0);
    a  = lerp_q30(wx, dot_at(cx, cy, cz, x0, y0, z0),
                  dot_at(cx + 16'd1, cy, cz, x1, y0, z0));
    b  = lerp_q30(wx, dot_at(cx, cy + 16'd1, cz, x0, y1, z0),
                  dot_at(cx + 16'd1, cy + 16'd1, cz, x1, y1, z0));
    lo = lerp_q30(wy, a, b);
    a  = lerp_q30(wx, dot_at(cx, cy, cz + 16'd1, x0, y0, z1),
                  dot_at(cx + 16'd1, cy, cz + 16'd1, x1, y0, z1));
    b  = lerp_q30(wx, dot_at(cx, cy + 16'd1, cz + 16'd1, x0, y1, z1),
                  dot_at(cx + 16'd1, cy + 16'd1, cz + 16'd1, x1, y1, z1));
    hi = lerp_q30(wy, a, b);
    r  = (lerp_q30(wz, lo, hi) + 8192) >>> 14;
    return r[19:0];
  endfunction

  assign pending_o    = noise_expected.size();
  assign fail_count_o = fails;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_i) begin
        case (operation_i)
          gn3_pkg::OP_EVAL:
            noise_expected.push_back(noise_at(coord_x_i, coord_y_i, coord_z_i));
          gn3_pkg::OP_PERM: perm_mirror[table_index_i] = perm_value_i;
          gn3_pkg::OP_GRAD: begin
            grad_mirror[table_index_i][0] = grad_x_in_i;
            grad_mirror[table_index_i][1] = grad_y_in_i;
            grad_mirror[table_index_i][2] = grad_z_in_i;
          end
          default: ;
        endcase
      end
      if (out_valid_i && out_ready_i) begin
        if (noise_expected.size() == 0) begin
          fails = fails + 1;
          if (fails <= 10)
            $display("unexpected noise word %0d", noise_value_i);
        end else begin
          if (noise_value_i !== noise_expected[0]) begin
            fails = fails + 1;
            if (fails <= 10)
              $display("noise_value mismatch: expected %0d actual %0d",
                       noise_expected[0], noise_value_i);
          end
          void'(noise_expected.pop_front());
        end
      end
    end
  end
endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// Top of the gradient_noise_3d_top testbench: clock, reset, stimulus and verdict.
// Depends on gn3_pkg, gradient_noise_3d_top and noise_checker.
module testbench;
  // Selector value with no operation behind it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic [1:0]         operation_i = gn3_pkg::OP_EVAL;
  logic signed [31:0] coord_x_i = '0;
  logic signed [31:0] coord_y_i = '0;
  logic signed [31:0] coord_z_i = '0;
  logic [7:0]         table_index_i = '0;
  logic [7:0]         perm_value_i = '0;
  logic signed [15:0] grad_x_in_i = '0;
  logic signed [15:0] grad_y_in_i = '0;
  logic signed [15:0] grad_z_in_i = '0;
  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [19:0] noise_value_o;

  int  fail_count;
  int  pending;
  int  cycle_count = 0;
  bit  quiet_phase = 1'b0;   // no idling on either side once set
  int  stall_left = 0;

  localparam int CYCLE_LIMIT = 400000;

  // Clock: 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  gradient_noise_3d_top dut (.*);

  noise_checker checker_i (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_i(in_ready_o), .operation_i,
    .coord_x_i, .coord_y_i, .coord_z_i, .table_index_i, .perm_value_i,
    .grad_x_in_i, .grad_y_in_i, .grad_z_in_i,
    .out_valid_i(out_valid_o), .out_ready_i, .noise_value_i(noise_value_o),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  // Watchdog: give up if the run hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("gradient_noise_3d_top verification failed");
      $finish;
    end
  end

  // Output side: drop ready for random bursts.
  always @(posedge clk_i) begin
    if (!rst_ni || quiet_phase) begin
      out_ready_i <= rst_ni;
      stall_left  <= 0;
    end else if (stall_left > 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= stall_left - 1;
    end else if ($urandom_range(0, 9) == 0) begin
      out_ready_i <= 1'b0;
      stall_left  <= $urandom_range(0, 12);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Present one word and hold it until the handshake completes.
  // Idle first for a random burst now and then, unless in the quiet phase.
  task automatic send_word(logic [1:0] op, logic [31:0] px, logic [31:0] py,
                           logic [31:0] pz, logic [7:0] idx, logic [7:0] pv,
                           logic [15:0] gx, logic [15:0] gy, logic [15:0] gz);
    int gap;
    if (!quiet_phase && $urandom_range(0, 7) == 0) begin
      gap = $urandom_range(1, 13);
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i    <= 1'b1;
    operation_i   <= op;
    coord_x_i     <= px;
    coord_y_i     <= py;
    coord_z_i     <= pz;
    table_index_i <= idx;
    perm_value_i  <= pv;
    grad_x_in_i   <= gx;
    grad_y_in_i   <= gy;
    grad_z_in_i   <= gz;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  task automatic eval_at(logic [31:0] px, logic [31:0] py, logic [31:0] pz);
    send_word(gn3_pkg::OP_EVAL, px, py, pz, 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  task automatic random_word();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 72)
      eval_at($urandom, $urandom, $urandom);
    else if (pick < 84)
      send_word(gn3_pkg::OP_PERM, $urandom, $urandom, $urandom, 8'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else if (pick < 96)
      send_word(gn3_pkg::OP_GRAD, $urandom, $urandom, $urandom, 8'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
    else
      send_word(OP_UNUSED, $urandom, $urandom, $urandom, 8'($urandom),
                8'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Fill every entry of both tables so no evaluation reads an unwritten one.
    for (int i = 0; i < 256; i++)
      send_word(gn3_pkg::OP_PERM, '0, '0, '0, 8'(i), 8'($urandom), '0, '0, '0);
    for (int i = 0; i < 256; i++)
      send_word(gn3_pkg::OP_GRAD, '0, '0, '0, 8'(i), '0,
                16'($urandom), 16'($urandom), 16'($urandom));

    // Directed: extreme gradients, corner points, cell wrap, unused selector.
    send_word(gn3_pkg::OP_GRAD, '0, '0, '0, 8'd0, '0, 16'h7FFF, 16'h8000, 16'h7FFF);
    send_word(gn3_pkg::OP_GRAD, '0, '0, '0, 8'd255, '0, 16'h8000, 16'h8000, 16'h8000);
    send_word(gn3_pkg::OP_PERM, '0, '0, '0, 8'd255, 8'd255, '0, '0, '0);
    send_word(gn3_pkg::OP_PERM, '0, '0, '0, 8'd0, 8'd0, '0, '0, '0);
    eval_at(32'h0, 32'h0, 32'h0);
    eval_at(32'h0000_FFFF, 32'h0000_FFFF, 32'h0000_FFFF);
    eval_at(32'h0000_8000, 32'h0000_8000, 32'h0000_8000);
    eval_at(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
    eval_at(32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
    eval_at(32'hFFFF_FFFF, 32'hFFFF_0000, 32'hFFFF_8000);
    eval_at(32'hFFFF_C000, 32'h0000_4000, 32'h7FFF_0001);
    send_word(OP_UNUSED, $urandom, $urandom, $urandom, 8'($urandom), 8'($urandom),
              16'($urandom), 16'($urandom), 16'($urandom));
    eval_at(32'h0001_0000, 32'hFFFF_FFFF, 32'h0000_0001);
    send_word(gn3_pkg::OP_GRAD, '0, '0, '0, 8'd7, '0, 16'h0000, 16'h0000, 16'h0000);
    eval_at(32'h8000_FFFF, 32'h7FFF_0000, 32'h0000_0000);

    // Random mix; the last stretch runs with no idling.
    for (int n = 0; n < 720; n++) begin
      if (n == 620)
        quiet_phase = 1'b1;
      random_word();
    end
    in_valid_i <= 1'b0;

    // Drain, then let the pipeline settle.
    while (pending != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    if (fail_count == 0)
      $display("gradient_noise_3d_top verification clean");
    else
      $display("gradient_noise_3d_top verification failed");
    $finish;
  end
endmodule
